/* rtl/core/aowbm_pkg.sv */
// Package for the allocate-on-write block map core.
// Holds field widths, status codes and the controller/datapath command and status types.
// Depends on nothing; every other file of the core refers to it by scoped names.
`default_nettype none

package aowbm_pkg;

    // Field widths of the input and result items.
    localparam int FILE_W   = 4;
    localparam int OFFSET_W = 28;
    localparam int SECTOR_W = 23;
    localparam int STATUS_W = 2;

    // Geometry: 16 files, 256 logical blocks of 1 MiB per file, 4096 physical blocks.
    localparam int MAX_FILES   = 16;
    localparam int LBLK_W      = 8;
    localparam int BLOCK_SHIFT = 20;
    localparam int SECTOR_SHIFT = 9;
    localparam int PBLK_W      = 12;
    localparam int IDX_W       = FILE_W + LBLK_W;
    localparam int MAP_DEPTH   = 1 << IDX_W;
    localparam int FCOUNT_W    = 9;

    // Offset bits inside one block that reach the sector address.
    localparam int INBLK_SEC_W = BLOCK_SHIFT - SECTOR_SHIFT;

    // Highest block number that is never handed out.
    localparam logic [PBLK_W-1:0] ALLOC_LIMIT = {PBLK_W{1'b1}};

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNMAPPED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic load;
        logic commit;
    } aowbm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic out_blocked;
    } aowbm_stat_t;

endpackage

`default_nettype wire

/* rtl/core/allocate_on_write_block_map_core.sv */
// Allocate-on-write block map core: top level joining controller and datapath.
// The accepted item's map entry is registered, and its result is committed to the result
// register in the look state unless a waiting result is stalled. A new item is taken only
// once the last is committed: the single map memory is read on accept, written on commit.
// A taken result frees the output register while the next item is already in progress.
// Reset is asynchronous and active low; then all 4096 map entries clear with input stalled.
`default_nettype none

module allocate_on_write_block_map_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output      logic                           in_stall,
    input  wire logic [aowbm_pkg::FILE_W-1:0]   file_id,
    input  wire logic [aowbm_pkg::OFFSET_W-1:0] byte_offset,
    input  wire logic                           is_write,
    output      logic                           out_valid,
    input  wire logic                           out_stall,
    output      logic [aowbm_pkg::SECTOR_W-1:0] sector_address,
    output      logic                           newly_allocated,
    output      logic [aowbm_pkg::STATUS_W-1:0] status,
    output      logic [aowbm_pkg::PBLK_W-1:0]   alloc_total
);

    aowbm_pkg::aowbm_cmd_t  cmd;
    aowbm_pkg::aowbm_stat_t stat;

    // Sequencing of clear, accept and commit.
    aowbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Map memory, counters and the result register.
    aowbm_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .file_id         (file_id),
        .byte_offset     (byte_offset),
        .is_write        (is_write),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .sector_address  (sector_address),
        .newly_allocated (newly_allocated),
        .status          (status),
        .alloc_total     (alloc_total)
    );

endmodule

`default_nettype wire

/* rtl/core/aowbm_ctrl.sv */
// Controller state machine of the allocate-on-write block map core.
// Sequences the clearing pass, item acceptance and result commit.
// Depends on aowbm_pkg for the command and status types.
`default_nettype none

module aowbm_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output      logic                in_stall,
    input  wire aowbm_pkg::aowbm_stat_t stat,
    output      aowbm_pkg::aowbm_cmd_t  cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Commands follow directly from the state and the handshakes.
    always_comb
    begin
        cmd.clear_step = (state_reg == S_CLEAR);
        cmd.load       = (state_reg == S_IDLE) && in_valid;
        cmd.commit     = (state_reg == S_LOOK) && !stat.out_blocked;
    end

    assign in_stall = (state_reg != S_IDLE);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (!stat.out_blocked)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // State register; reset starts the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/aowbm_datapath.sv */
// Datapath of the allocate-on-write block map core: map memory, free-block
// counter, per-file block counts and the result register.
// Depends on aowbm_pkg for widths, status codes and the command and status types.
`default_nettype none

module aowbm_datapath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire aowbm_pkg::aowbm_cmd_t                 cmd,
    output      aowbm_pkg::aowbm_stat_t                stat,
    input  wire logic [aowbm_pkg::FILE_W-1:0]          file_id,
    input  wire logic [aowbm_pkg::OFFSET_W-1:0]        byte_offset,
    input  wire logic                                  is_write,
    output      logic                                  out_valid,
    input  wire logic                                  out_stall,
    output      logic [aowbm_pkg::SECTOR_W-1:0]        sector_address,
    output      logic                                  newly_allocated,
    output      logic [aowbm_pkg::STATUS_W-1:0]        status,
    output      logic [aowbm_pkg::PBLK_W-1:0]          alloc_total
);

    localparam int IDX_W    = aowbm_pkg::IDX_W;
    localparam int PBLK_W   = aowbm_pkg::PBLK_W;
    localparam int FILE_W   = aowbm_pkg::FILE_W;
    localparam int SEC_LO_W = aowbm_pkg::INBLK_SEC_W;

    // Map memory: valid bit over physical block number.
    logic [PBLK_W:0] map_mem [aowbm_pkg::MAP_DEPTH];
    logic [PBLK_W:0] rdata_reg;

    // Captured item.
    logic [IDX_W-1:0]    idx_reg;
    logic [FILE_W-1:0]   fid_reg;
    logic [SEC_LO_W-1:0] sec_lo_reg;
    logic                wr_reg;

    // Allocation state.
    logic [PBLK_W-1:0] next_free_reg;
    logic [PBLK_W-1:0] next_free_next;
    logic [aowbm_pkg::FCOUNT_W-1:0] fcount_reg [aowbm_pkg::MAX_FILES];
    logic [IDX_W-1:0]  clr_cnt_reg;

    // Result register.
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [aowbm_pkg::SECTOR_W-1:0]  sector_reg;
    logic [aowbm_pkg::SECTOR_W-1:0]  sector_next;
    logic                            fresh_reg;
    logic                            fresh_next;
    logic [aowbm_pkg::STATUS_W-1:0]  status_reg;
    logic [aowbm_pkg::STATUS_W-1:0]  status_next;
    logic [PBLK_W-1:0]               used_reg;

    logic            alloc;
    logic [IDX_W-1:0] rd_idx;

    // The map index is the file id over the logical block number.
    assign rd_idx = {file_id,
                     byte_offset[aowbm_pkg::BLOCK_SHIFT +: aowbm_pkg::LBLK_W]};

    // Decide the outcome of the captured item from the registered map entry.
    always_comb
    begin
        alloc       = 1'b0;
        fresh_next  = 1'b0;
        sector_next = '0;
        status_next = aowbm_pkg::STATUS_OK;
        if (rdata_reg[PBLK_W])
        begin
            sector_next = {rdata_reg[PBLK_W-1:0], sec_lo_reg};
        end
        else if (!wr_reg)
        begin
            status_next = aowbm_pkg::STATUS_UNMAPPED;
        end
        else if (next_free_reg == aowbm_pkg::ALLOC_LIMIT)
        begin
            status_next = aowbm_pkg::STATUS_FULL;
        end
        else
        begin
            alloc       = 1'b1;
            fresh_next  = 1'b1;
            sector_next = {next_free_reg, sec_lo_reg};
        end
    end

    assign next_free_next = (cmd.commit && alloc) ? next_free_reg + 1'b1 : next_free_reg;

    // Map memory: clearing sweep or allocation write, registered read on accept.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            map_mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.commit && alloc)
        begin
            map_mem[idx_reg] <= {1'b1, next_free_reg};
        end
        if (cmd.load)
        begin
            rdata_reg <= map_mem[rd_idx];
        end
    end

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg    <= rd_idx;
            fid_reg    <= file_id;
            sec_lo_reg <= byte_offset[aowbm_pkg::SECTOR_SHIFT +: SEC_LO_W];
            wr_reg     <= is_write;
        end
    end

    // Free-block counter, per-file counts and the clearing address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_free_reg <= '0;
            clr_cnt_reg   <= '0;
            for (int i = 0; i < aowbm_pkg::MAX_FILES; i++)
            begin
                fcount_reg[i] <= '0;
            end
        end
        else
        begin
            next_free_reg <= next_free_next;
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.commit && alloc)
            begin
                fcount_reg[fid_reg] <= fcount_reg[fid_reg] + 1'b1;
            end
        end
    end

    // Result register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            sector_reg <= sector_next;
            fresh_reg  <= fresh_next;
            status_reg <= status_next;
            used_reg   <= next_free_next;
        end
    end

    always_comb
    begin
        stat.clear_last  = (clr_cnt_reg == {IDX_W{1'b1}});
        stat.out_blocked = out_valid_reg && out_stall;
    end

    assign out_valid       = out_valid_reg;
    assign sector_address  = sector_reg;
    assign newly_allocated = fresh_reg;
    assign status          = status_reg;
    assign alloc_total     = used_reg;

`ifndef NO_ASSERTIONS
    // A result is never written over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && out_stall))
        else $error("result register overwritten while stalled");

    // The free-block counter moves only on a committed allocation.
    a_free_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg != $past(next_free_reg)) |-> $past(cmd.commit && alloc))
        else $error("free-block counter changed without an allocation");

    // A fresh block always comes with a good status.
    a_fresh_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && fresh_reg) |-> (status_reg == aowbm_pkg::STATUS_OK))
        else $error("fresh block reported with an error status");

    // A failed access reports a zero sector address.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != aowbm_pkg::STATUS_OK)) |-> (sector_reg == '0))
        else $error("failed access has a nonzero sector address");
`endif

endmodule

`default_nettype wire

/* tb/tb_allocate_on_write_block_map_core.sv */
// Self-checking testbench for the allocate-on-write block map core.
// Predicts every access from its own copy of the per-file block map and the block counter.
// Depends on aowbm_pkg and allocate_on_write_block_map_core.
module tb_allocate_on_write_block_map_core;
    timeunit 1ns;
    timeprecision 1ps;

    // Generous cycle ceiling: clearing pass plus several thousand stalled accesses.
    localparam int unsigned RUN_LIMIT = 400000;

    typedef struct packed {
        logic [aowbm_pkg::SECTOR_W-1:0] sector;
        logic                           fresh;
        logic [aowbm_pkg::STATUS_W-1:0] st;
        logic [aowbm_pkg::PBLK_W-1:0]   used;
    } access_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [aowbm_pkg::FILE_W-1:0]   file_id;
    logic [aowbm_pkg::OFFSET_W-1:0] byte_offset;
    logic                           is_write;
    logic                           out_valid;
    logic                           out_stall;
    logic [aowbm_pkg::SECTOR_W-1:0] sector_address;
    logic                           newly_allocated;
    logic [aowbm_pkg::STATUS_W-1:0] status;
    logic [aowbm_pkg::PBLK_W-1:0]   alloc_total;

    // Predicted block map, allocation counter and per-file block counts.
    logic                           entry_mapped [aowbm_pkg::MAP_DEPTH] = '{default: 1'b0};
    logic [aowbm_pkg::PBLK_W-1:0]   phys_of [aowbm_pkg::MAP_DEPTH];
    logic [aowbm_pkg::PBLK_W-1:0]   alloc_next = '0;
    logic [aowbm_pkg::FCOUNT_W-1:0] file_blocks [aowbm_pkg::MAX_FILES] = '{default: '0};
    logic [aowbm_pkg::IDX_W-1:0]    mapped_list [$];
    logic [aowbm_pkg::IDX_W-1:0]    hole_idx = '0;

    access_result_t      expected_results [$];
    int unsigned         mismatches = 0;
    int unsigned         cycle_count = 0;
    logic                quiet = 1'b0;

    allocate_on_write_block_map_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .file_id         (file_id),
        .byte_offset     (byte_offset),
        .is_write        (is_write),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .sector_address  (sector_address),
        .newly_allocated (newly_allocated),
        .status          (status),
        .alloc_total     (alloc_total)
    );

    // Clock with an 8 ns period.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Cycle ceiling in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side stalls at random except during the quiet stretch.
    always @(posedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(99) < 9);
    end

    // Works out one access against the predicted map and updates it.
    function automatic access_result_t predict_access(logic [aowbm_pkg::FILE_W-1:0] fid,
                                                      logic [aowbm_pkg::OFFSET_W-1:0] off,
                                                      logic wr);
        access_result_t r;
        logic [aowbm_pkg::IDX_W-1:0] idx;
        r = '0;
        idx = {fid, off[aowbm_pkg::OFFSET_W-1:aowbm_pkg::BLOCK_SHIFT]};
        r.st = aowbm_pkg::STATUS_OK;
        if (!entry_mapped[idx])
        begin
            if (!wr)
                r.st = aowbm_pkg::STATUS_UNMAPPED;
            else if (alloc_next >= aowbm_pkg::ALLOC_LIMIT)
                r.st = aowbm_pkg::STATUS_FULL;
            else
            begin
                phys_of[idx] = alloc_next;
                entry_mapped[idx] = 1'b1;
                mapped_list.push_back(idx);
                alloc_next = alloc_next + 1'b1;
                file_blocks[fid] = file_blocks[fid] + 1'b1;
                r.fresh = 1'b1;
            end
        end
        if (r.st == aowbm_pkg::STATUS_OK)
            r.sector = {phys_of[idx],
                        off[aowbm_pkg::BLOCK_SHIFT-1:aowbm_pkg::SECTOR_SHIFT]};
        r.used = alloc_next;
        return r;
    endfunction

    // Random offset inside the given logical block.
    function automatic logic [aowbm_pkg::OFFSET_W-1:0] offset_in(
        logic [aowbm_pkg::LBLK_W-1:0] lblk);
        logic [31:0] rnd;
        rnd = $urandom;
        return {lblk, rnd[aowbm_pkg::BLOCK_SHIFT-1:0]};
    endfunction

    // Number of idle cycles before the next item.
    function automatic int unsigned idle_gap();
        int unsigned n = 0;
        while (!quiet && $urandom_range(99) < 9)
            n++;
        return n;
    endfunction

    // Offers one access and holds it until the block's input stall is low.
    task automatic send_access(input logic [aowbm_pkg::FILE_W-1:0] fid,
                               input logic [aowbm_pkg::OFFSET_W-1:0] off,
                               input logic wr);
        int unsigned gap;
        gap = idle_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        file_id <= fid;
        byte_offset <= off;
        is_write <= wr;
        expected_results.push_back(predict_access(fid, off, wr));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Each taken result is compared with the oldest prediction.
    always @(posedge clk)
    begin
        access_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("sector_address: expected no result, actual %0d", sector_address);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("sector_address", want.sector, sector_address);
                check_field("newly_allocated", want.fresh, newly_allocated);
                check_field("status", want.st, status);
                check_field("alloc_total", want.used, alloc_total);
            end
        end
    end

    // Field extremes, first allocations, rewrites and reads of unmapped blocks.
    task automatic test_directed();
        send_access(4'h0, 28'h0000000, 1'b0);
        send_access(4'h0, 28'h0000000, 1'b1);
        send_access(4'h0, 28'h00FFFFF, 1'b1);
        send_access(4'h0, 28'h00001FF, 1'b0);
        send_access(4'h0, 28'h0000200, 1'b0);
        send_access(4'hF, 28'hFFFFFFF, 1'b1);
        send_access(4'hF, 28'hFFFFFFF, 1'b0);
        send_access(4'hF, 28'hFF00000, 1'b0);
        send_access(4'hF, 28'h0000000, 1'b0);
        send_access(4'hA, 28'hAAAAAAA, 1'b1);
        send_access(4'h5, 28'h5555555, 1'b1);
        send_access(4'hA, 28'hAA00000, 1'b0);
        send_access(4'h5, 28'h55FFFFF, 1'b1);
        send_access(4'h7, 28'h8000000, 1'b0);
        send_access(4'h7, 28'h8012345, 1'b1);
        send_access(4'h0, 28'hFFFFFFF, 1'b0);
    endtask

    // Mix of accesses to mapped blocks, fresh writes and random reads.
    task automatic test_random_mix(input int unsigned count);
        int unsigned pick;
        logic [aowbm_pkg::IDX_W-1:0] idx;
        logic [31:0] rnd;
        repeat (count)
        begin
            pick = $urandom_range(99);
            rnd = $urandom;
            if (pick < 40 && mapped_list.size() != 0)
            begin
                idx = mapped_list[$urandom_range(mapped_list.size() - 1)];
                send_access(idx[aowbm_pkg::IDX_W-1:aowbm_pkg::LBLK_W],
                            offset_in(idx[aowbm_pkg::LBLK_W-1:0]), rnd[0]);
            end
            else
                send_access(rnd[aowbm_pkg::FILE_W-1:0],
                            offset_in(rnd[aowbm_pkg::FILE_W +: aowbm_pkg::LBLK_W]),
                            pick < 70);
        end
    endtask

    // Writes every unmapped entry until the physical blocks run out; the first half
    // runs with no idling on either side.
    task automatic test_fill_to_full();
        logic [aowbm_pkg::IDX_W-1:0] idx;
        for (int i = 0; i < aowbm_pkg::MAP_DEPTH; i++)
        begin
            idx = i[aowbm_pkg::IDX_W-1:0];
            quiet = (i < aowbm_pkg::MAP_DEPTH / 2);
            if (!entry_mapped[idx])
            begin
                send_access(idx[aowbm_pkg::IDX_W-1:aowbm_pkg::LBLK_W],
                            offset_in(idx[aowbm_pkg::LBLK_W-1:0]), 1'b1);
                if (!entry_mapped[idx])
                    hole_idx = idx;
            end
        end
        quiet = 1'b0;
    endtask

    // With no free block left: the remaining hole reports out-of-space or unmapped,
    // everything else still resolves.
    task automatic test_after_full(input int unsigned count);
        logic [aowbm_pkg::IDX_W-1:0] idx;
        logic [31:0] rnd;
        repeat (count)
        begin
            rnd = $urandom;
            if ($urandom_range(99) < 30)
                idx = hole_idx;
            else
                idx = rnd[aowbm_pkg::IDX_W-1:0];
            send_access(idx[aowbm_pkg::IDX_W-1:aowbm_pkg::LBLK_W],
                        offset_in(idx[aowbm_pkg::LBLK_W-1:0]), rnd[aowbm_pkg::IDX_W]);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        file_id <= '0;
        byte_offset <= '0;
        is_write <= 1'b0;
        out_stall <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mix(1600);
        test_fill_to_full();
        test_after_full(200);
        in_valid <= 1'b0;

        // Drain outstanding results, then allow the pipeline to settle.
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
